### design/dbpm_pkg.sv
// Shared types and constants for the dual battery protection monitor.
`timescale 1ns / 1ps

package dbpm_pkg;

   // Register indexes on the configuration port
   typedef enum logic [2:0] {
      REG_VOLT_LOW_LIMIT    = 3'd0,
      REG_VOLT_HIGH_LIMIT   = 3'd1,
      REG_VOLT_HYSTERESIS   = 3'd2,
      REG_TEMP_LOW_LIMIT    = 3'd3,
      REG_TEMP_HIGH_LIMIT   = 3'd4,
      REG_TEMP_HYSTERESIS   = 3'd5,
      REG_CURRENT_LOW_LIMIT = 3'd6,
      REG_VOLT_WARN_MARGIN  = 3'd7
   } csr_index_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned HYST_W      = 15;

   // Margin above the heater threshold that raises the cold warning
   localparam int unsigned TEMP_WARN_MARGIN = 0;

   // Check mask bit positions
   localparam int unsigned CHECK_CURRENT = 0;
   localparam int unsigned CHECK_TEMP    = 1;
   localparam int unsigned CHECK_VOLT    = 2;
   localparam int unsigned CHECK_WARN    = 3;
   localparam int unsigned CHECK_MASK_W  = 4;

   // Result word: 10 status bits padded to two bytes
   localparam int unsigned RSP_STATUS_W = 10;
   localparam int unsigned RSP_DATA_W   = 16;

   typedef struct packed {
      logic [15:0]       volt_low_limit;
      logic [15:0]       volt_high_limit;
      logic [HYST_W-1:0] volt_hysteresis;
      logic [15:0]       temp_low_limit;
      logic [15:0]       temp_high_limit;
      logic [HYST_W-1:0] temp_hysteresis;
      logic [15:0]       current_low_limit;
      logic [15:0]       volt_warn_margin;
   } cfg_type;

   // Per-battery check outcomes, before the check mask is applied
   typedef struct packed {
      logic current_low;
      logic too_cold;
      logic conn_next;
      logic cold_warn;
      logic power_warn;
   } bat_flags_type;

endpackage

### design/dual_battery_protection_monitor_unit.sv
// Top level of the dual battery protection monitor.
`timescale 1ns / 1ps
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  req     | in  | req_tvalid/req_tready  | tdata 8 samples, tuser check mask
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata 10 status bits, zero padded
//  csr     | in  | csr_valid/csr_ready    | csr_index 3b, csr_data 16b
//
// One reading set per cycle sustained while rsp is not stalled. A
// transfer lands in the input register; the checks then run against the
// status flops and the updated status is loaded into the result register.
// The status flops advance only when the result register can take the
// new word, so a stall on rsp backs up through the input stage.
// Reset (synchronous, high) connects both batteries, enables all FETs,
// clears heaters and warnings and loads the default limits. csr_ready is
// always high.

module dual_battery_protection_monitor_unit
   import dbpm_pkg::*;
#(
   parameter int unsigned SAMPLE_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // req_tdata, low bit up: bat1_voltage, bat2_voltage, bat1_current_a,
   // bat1_current_b, bat2_current_a, bat2_current_b, bat1_temperature,
   // bat2_temperature; SAMPLE_WIDTH bits each
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [8*SAMPLE_WIDTH-1:0] req_tdata,
   input  logic [CHECK_MASK_W-1:0]   req_tuser,   // check_mask
   // rsp_tdata, low bit up: bat1_connected_out, bat2_connected_out,
   // heater_out[1:0], charge_fet_out[3:0], cold_warning_out,
   // power_warning_out, zero padding
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   localparam int unsigned SW = SAMPLE_WIDTH;

   cfg_type cfg;

   dbpm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // input stage
   logic                    in_valid_ff, in_valid_in;
   logic [8*SW-1:0]         in_data_ff;
   logic [CHECK_MASK_W-1:0] in_mask_ff;

   // status flops
   logic       bat1_conn_ff, bat1_conn_in;
   logic       bat2_conn_ff, bat2_conn_in;
   logic [1:0] heater_ff, heater_in;
   logic [3:0] fet_ff, fet_in;
   logic       cold_ff, cold_in;
   logic       power_ff, power_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic advance, req_xfer, commit;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign commit     = in_valid_ff && advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   bat_flags_type b1_flags, b2_flags;

   dbpm_battery #(.SAMPLE_WIDTH(SW)) u_bat1 (
      .cfg         (cfg),
      .conn_now    (bat1_conn_ff),
      .voltage     (in_data_ff[0*SW +: SW]),
      .current_a   (in_data_ff[2*SW +: SW]),
      .current_b   (in_data_ff[3*SW +: SW]),
      .temperature (in_data_ff[6*SW +: SW]),
      .flags       (b1_flags)
   );

   dbpm_battery #(.SAMPLE_WIDTH(SW)) u_bat2 (
      .cfg         (cfg),
      .conn_now    (bat2_conn_ff),
      .voltage     (in_data_ff[1*SW +: SW]),
      .current_a   (in_data_ff[4*SW +: SW]),
      .current_b   (in_data_ff[5*SW +: SW]),
      .temperature (in_data_ff[7*SW +: SW]),
      .flags       (b2_flags)
   );

   // apply the enabled checks in order: current, temperature, voltage, warnings
   always_comb begin
      fet_in       = fet_ff;
      heater_in    = heater_ff;
      bat1_conn_in = bat1_conn_ff;
      bat2_conn_in = bat2_conn_ff;
      cold_in      = cold_ff;
      power_in     = power_ff;

      if (in_mask_ff[CHECK_CURRENT]) begin
         if (b1_flags.current_low) fet_in[1:0] = 2'b00;
         if (b2_flags.current_low) fet_in[3:2] = 2'b00;
      end
      if (in_mask_ff[CHECK_TEMP]) begin
         heater_in = heater_ff | {b2_flags.too_cold, b1_flags.too_cold};
      end
      if (in_mask_ff[CHECK_VOLT]) begin
         bat1_conn_in = b1_flags.conn_next;
         bat2_conn_in = b2_flags.conn_next;
      end
      if (in_mask_ff[CHECK_WARN]) begin
         cold_in  = b1_flags.cold_warn || b2_flags.cold_warn;
         power_in = b1_flags.power_warn || b2_flags.power_warn;
      end

      rsp_data_in = {(RSP_DATA_W - RSP_STATUS_W)'(0), power_in, cold_in, fet_in,
                     heater_in, bat2_conn_in, bat1_conn_in};

      in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bat1_conn_ff <= 1'b1;
         bat2_conn_ff <= 1'b1;
         heater_ff    <= 2'b00;
         fet_ff       <= 4'hF;
         cold_ff      <= 1'b0;
         power_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            bat1_conn_ff <= bat1_conn_in;
            bat2_conn_ff <= bat2_conn_in;
            heater_ff    <= heater_in;
            fet_ff       <= fet_in;
            cold_ff      <= cold_in;
            power_ff     <= power_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_tdata;
         in_mask_ff <= req_tuser;
      end
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

### design/dbpm_csr.sv
// Configuration register file for the battery protection monitor.
`timescale 1ns / 1ps

module dbpm_csr
   import dbpm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{volt_low_limit:    16'h0000,
                     volt_high_limit:   16'hFFFF,
                     volt_hysteresis:   '0,
                     temp_low_limit:    16'h0000,
                     temp_high_limit:   16'hFFFF,
                     temp_hysteresis:   '0,
                     current_low_limit: 16'h0000,
                     volt_warn_margin:  16'h0000};
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_VOLT_LOW_LIMIT:    cfg_ff.volt_low_limit    <= csr_data;
            REG_VOLT_HIGH_LIMIT:   cfg_ff.volt_high_limit   <= csr_data;
            REG_VOLT_HYSTERESIS:   cfg_ff.volt_hysteresis   <= csr_data[HYST_W-1:0];
            REG_TEMP_LOW_LIMIT:    cfg_ff.temp_low_limit    <= csr_data;
            REG_TEMP_HIGH_LIMIT:   cfg_ff.temp_high_limit   <= csr_data;
            REG_TEMP_HYSTERESIS:   cfg_ff.temp_hysteresis   <= csr_data[HYST_W-1:0];
            REG_CURRENT_LOW_LIMIT: cfg_ff.current_low_limit <= csr_data;
            REG_VOLT_WARN_MARGIN:  cfg_ff.volt_warn_margin  <= csr_data;
            default:               cfg_ff                   <= cfg_ff;
         endcase
      end
   end

endmodule

### design/dbpm_battery.sv
// Threshold checks for one battery's reading set.
`timescale 1ns / 1ps

module dbpm_battery
   import dbpm_pkg::*;
#(
   parameter int unsigned SAMPLE_WIDTH = 16
) (
   input  cfg_type                 cfg,
   input  logic                    conn_now,
   input  logic [SAMPLE_WIDTH-1:0] voltage,
   input  logic [SAMPLE_WIDTH-1:0] current_a,
   input  logic [SAMPLE_WIDTH-1:0] current_b,
   input  logic [SAMPLE_WIDTH-1:0] temperature,
   output bat_flags_type           flags
);

   // Wide enough that limit plus margin never wraps
   localparam int unsigned EW = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 2;

   logic [SAMPLE_WIDTH-1:0] isum;
   logic [EW-1:0] v, t, vl, vh, vhy, th, thy, tw, vw;
   logic          drop, restore;

   always_comb begin
      isum = current_a + current_b;   // wraps at sample width
      v    = EW'(voltage);
      t    = EW'(temperature);
      vl   = EW'(cfg.volt_low_limit);
      vh   = EW'(cfg.volt_high_limit);
      vhy  = EW'(cfg.volt_hysteresis);
      th   = EW'(cfg.temp_high_limit);
      thy  = EW'(cfg.temp_hysteresis);
      tw   = EW'(TEMP_WARN_MARGIN) + EW'(cfg.temp_low_limit);
      vw   = EW'(cfg.volt_warn_margin) + vl;

      drop    = (v < vl) || (v > vh) || (t > th);
      // a negative upper bound makes the strict test fail
      restore = (v > (vl + vhy)) && (vh >= vhy) && (v < (vh - vhy))
                && (th >= thy) && (t < (th - thy));

      flags.current_low = EW'(isum) < EW'(cfg.current_low_limit);
      flags.too_cold    = t < EW'(cfg.temp_low_limit);
      flags.conn_next   = restore ? 1'b1 : (drop ? 1'b0 : conn_now);
      flags.cold_warn   = t < tw;
      flags.power_warn  = v < vw;
   end

endmodule
